>>> rtl/crs_pkg.sv
// Shared types and constants for the Catmull-Rom segment evaluator.
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int unsigned PIPE_LATENCY = 9;

    // Opcodes.
    localparam logic OP_POSITION = 1'b0;
    localparam logic OP_TANGENT  = 1'b1;

    // Control that travels with each transaction down the pipeline.
    typedef struct packed {
        logic valid;
        logic op;
    } t_ctl;

endpackage
`default_nettype wire

>>> rtl/crs_coef.sv
// Two stages: t clamp and basis coefficients, then Horner operand select.
`timescale 1ns / 1ps
`default_nettype none
module crs_coef #(
    parameter int unsigned COORD_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned ACC_WIDTH   = COORD_WIDTH + 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  crs_pkg::t_ctl                       i_ctl,
    input  wire signed [COORD_WIDTH-1:0]        i_p0,
    input  wire signed [COORD_WIDTH-1:0]        i_p1,
    input  wire signed [COORD_WIDTH-1:0]        i_p2,
    input  wire signed [COORD_WIDTH-1:0]        i_p3,
    input  wire signed [FRAC_BITS+1:0]          i_t,
    output crs_pkg::t_ctl                       o_ctl,
    output logic        [FRAC_BITS:0]           o_t,
    output logic signed [ACC_WIDTH-1:0]         o_x,
    output logic signed [ACC_WIDTH-1:0]         o_add,
    output logic signed [ACC_WIDTH-1:0]         o_a1,
    output logic signed [ACC_WIDTH-1:0]         o_a0
);
    import crs_pkg::*;

    localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic signed [ACC_WIDTH-1:0] w_p0, w_p1, w_p2, w_p3;
    logic signed [ACC_WIDTH-1:0] n_a0, n_a1, n_a2, n_a3;
    logic        [FRAC_BITS:0]   n_t;

    t_ctl                        r_ctl1, r_ctl2;
    logic        [FRAC_BITS:0]   r_t1, r_t2;
    logic signed [ACC_WIDTH-1:0] r_a0_1, r_a1_1, r_a2_1, r_a3_1;
    logic signed [ACC_WIDTH-1:0] r_x, r_add, r_a1_2, r_a0_2;
    logic signed [ACC_WIDTH-1:0] n_x, n_add;

    always_comb begin
        w_p0 = ACC_WIDTH'(i_p0);
        w_p1 = ACC_WIDTH'(i_p1);
        w_p2 = ACC_WIDTH'(i_p2);
        w_p3 = ACC_WIDTH'(i_p3);
        n_a0 = w_p1 <<< 1;
        n_a1 = w_p2 - w_p0;
        n_a2 = (w_p0 <<< 1) - (w_p1 <<< 2) - w_p1 + (w_p2 <<< 2) - w_p3;
        n_a3 = (w_p1 <<< 1) + w_p1 - (w_p2 <<< 1) - w_p2 + w_p3 - w_p0;
        if (i_t[FRAC_BITS+1]) begin
            n_t = '0;
        end else if (i_t[FRAC_BITS:0] > T_ONE) begin
            n_t = T_ONE;
        end else begin
            n_t = i_t[FRAC_BITS:0];
        end
    end

    // Tangent uses 3*a3 and 2*a2 as the leading Horner terms.
    always_comb begin
        if (r_ctl1.op == OP_TANGENT) begin
            n_x   = (r_a3_1 <<< 1) + r_a3_1;
            n_add = r_a2_1 <<< 1;
        end else begin
            n_x   = r_a3_1;
            n_add = r_a2_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1   <= n_t;
        r_a0_1 <= n_a0;
        r_a1_1 <= n_a1;
        r_a2_1 <= n_a2;
        r_a3_1 <= n_a3;
        r_t2   <= r_t1;
        r_x    <= n_x;
        r_add  <= n_add;
        r_a1_2 <= r_a1_1;
        r_a0_2 <= r_a0_1;
    end

    assign o_ctl = r_ctl2;
    assign o_t   = r_t2;
    assign o_x   = r_x;
    assign o_add = r_add;
    assign o_a1  = r_a1_2;
    assign o_a0  = r_a0_2;
endmodule
`default_nettype wire

>>> rtl/crs_step.sv
// One Horner step: multiply by t, round to nearest (ties up), add.
`timescale 1ns / 1ps
`default_nettype none
module crs_step #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned ACC_WIDTH = 40
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  crs_pkg::t_ctl                i_ctl,
    input  wire        [FRAC_BITS:0]     i_t,
    input  wire signed [ACC_WIDTH-1:0]   i_x,
    input  wire signed [ACC_WIDTH-1:0]   i_add,
    output crs_pkg::t_ctl                o_ctl,
    output logic signed [ACC_WIDTH-1:0]  o_sum
);
    import crs_pkg::*;

    localparam int unsigned PROD_WIDTH = ACC_WIDTH + FRAC_BITS + 2;
    localparam logic signed [PROD_WIDTH-1:0] HALF =
        PROD_WIDTH'(1) << (FRAC_BITS - 1);

    t_ctl                         r_ctl_a, r_ctl_b;
    logic signed [PROD_WIDTH-1:0] r_prod;
    logic signed [ACC_WIDTH-1:0]  r_add, r_sum;
    logic signed [PROD_WIDTH-1:0] n_prod, n_round;
    logic signed [FRAC_BITS+1:0]  w_t;

    always_comb begin
        w_t     = $signed({1'b0, i_t});
        n_prod  = PROD_WIDTH'(i_x) * PROD_WIDTH'(w_t);
        n_round = r_prod + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
        end else begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_add  <= i_add;
        r_sum  <= r_add + n_round[FRAC_BITS +: ACC_WIDTH];
    end

    assign o_ctl = r_ctl_b;
    assign o_sum = r_sum;
endmodule
`default_nettype wire

>>> rtl/catmull_rom_spline_eval.sv
// Top level: uniform Catmull-Rom segment evaluator, one axis per transaction.
//
// Usage: drive i_opcode, the four control values and i_param_t, and raise
// start. A transaction is taken at each rising edge with start high and busy
// low; busy is only high while i_rst_n is asserted, so one transaction can
// enter every cycle. Opcode 0 returns the position, opcode 1 the derivative
// with respect to t; t is clamped to 0..1.
// The result appears on o_value / o_saturated with o_strobe high for
// exactly one cycle, registered after the pipeline stages listed below.
// Throughput: one transaction per cycle. The depth is set by two coefficient
// stages, three multiply/round/add Horner steps of two stages each (the t
// multiplier is the critical unit) and one saturation stage.
// Reset (synchronous, active low) clears all valid bits; transactions in
// flight are dropped. The receiver cannot stall: results are not held, so
// it must take each one in the cycle o_strobe is high.
// o_saturated flags a result clamped to the signed COORD_WIDTH range.
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_spline_eval #(
    parameter int unsigned COORD_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire                           i_opcode,
    input  wire signed [COORD_WIDTH-1:0]  i_point_before,
    input  wire signed [COORD_WIDTH-1:0]  i_segment_start,
    input  wire signed [COORD_WIDTH-1:0]  i_segment_end,
    input  wire signed [COORD_WIDTH-1:0]  i_point_after,
    input  wire signed [FRAC_BITS+1:0]    i_param_t,
    output logic                          o_strobe,
    output logic signed [COORD_WIDTH-1:0] o_value,
    output logic                          o_saturated
);
    import crs_pkg::*;

    localparam int unsigned ACC_WIDTH = COORD_WIDTH + 8;
    localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic signed [COORD_WIDTH-1:0] VAL_MAX =
        {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] VAL_MIN =
        {1'b1, {(COORD_WIDTH-1){1'b0}}};

    t_ctl                        w_in_ctl, w_c_ctl, w_s1_ctl, w_s2_ctl, w_s3_ctl;
    logic        [FRAC_BITS:0]   w_c_t;
    logic signed [ACC_WIDTH-1:0] w_c_x, w_c_add, w_c_a1, w_c_a0;
    logic signed [ACC_WIDTH-1:0] w_s1_sum, w_s2_sum, w_s3_sum;

    // Side data delayed to line up with each Horner step.
    logic        [FRAC_BITS:0]   r_t_d1 [2];
    logic        [FRAC_BITS:0]   r_t_d2 [2];
    logic signed [ACC_WIDTH-1:0] r_a1_d [2];
    logic signed [ACC_WIDTH-1:0] r_a0_d [4];

    logic        [FRAC_BITS:0]   w_s3_t;
    logic signed [ACC_WIDTH-1:0] w_s3_add;

    logic signed [ACC_WIDTH-1:0] n_inc;
    logic signed [ACC_WIDTH-2:0] n_half;
    logic signed [COORD_WIDTH-1:0] n_value;
    logic                        n_sat;

    logic                        r_strobe, r_sat;
    logic signed [COORD_WIDTH-1:0] r_value;

    assign busy     = !i_rst_n;
    assign w_in_ctl = '{valid: start && !busy, op: i_opcode};

    crs_coef #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_in_ctl),
        .i_p0    (i_point_before),
        .i_p1    (i_segment_start),
        .i_p2    (i_segment_end),
        .i_p3    (i_point_after),
        .i_t     (i_param_t),
        .o_ctl   (w_c_ctl),
        .o_t     (w_c_t),
        .o_x     (w_c_x),
        .o_add   (w_c_add),
        .o_a1    (w_c_a1),
        .o_a0    (w_c_a0)
    );

    crs_step #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_step1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_c_ctl),
        .i_t     (w_c_t),
        .i_x     (w_c_x),
        .i_add   (w_c_add),
        .o_ctl   (w_s1_ctl),
        .o_sum   (w_s1_sum)
    );

    crs_step #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_step2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_s1_ctl),
        .i_t     (r_t_d1[1]),
        .i_x     (w_s1_sum),
        .i_add   (r_a1_d[1]),
        .o_ctl   (w_s2_ctl),
        .o_sum   (w_s2_sum)
    );

    // Tangent stops after two steps: multiply by exactly 1.0 and add nothing.
    always_comb begin
        if (w_s2_ctl.op == OP_TANGENT) begin
            w_s3_t   = T_ONE;
            w_s3_add = '0;
        end else begin
            w_s3_t   = r_t_d2[1];
            w_s3_add = r_a0_d[3];
        end
    end

    crs_step #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_step3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_s2_ctl),
        .i_t     (w_s3_t),
        .i_x     (w_s2_sum),
        .i_add   (w_s3_add),
        .o_ctl   (w_s3_ctl),
        .o_sum   (w_s3_sum)
    );

    always_ff @(posedge i_clk) begin
        r_t_d1[0] <= w_c_t;
        r_t_d1[1] <= r_t_d1[0];
        r_t_d2[0] <= r_t_d1[1];
        r_t_d2[1] <= r_t_d2[0];
        r_a1_d[0] <= w_c_a1;
        r_a1_d[1] <= r_a1_d[0];
        r_a0_d[0] <= w_c_a0;
        r_a0_d[1] <= r_a0_d[0];
        r_a0_d[2] <= r_a0_d[1];
        r_a0_d[3] <= r_a0_d[2];
    end

    // Halve with ties up, then clamp to the coordinate range.
    always_comb begin
        n_inc  = w_s3_sum + ACC_WIDTH'(1);
        n_half = n_inc[ACC_WIDTH-1:1];
        if (n_half[ACC_WIDTH-2:COORD_WIDTH-1] == '0 ||
            n_half[ACC_WIDTH-2:COORD_WIDTH-1] == '1) begin
            n_value = n_half[COORD_WIDTH-1:0];
            n_sat   = 1'b0;
        end else begin
            n_value = n_half[ACC_WIDTH-2] ? VAL_MIN : VAL_MAX;
            n_sat   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_s3_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    assign o_strobe    = r_strobe;
    assign o_value     = r_value;
    assign o_saturated = r_sat;

    // Every result traces back to an earlier accepted transaction.
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without a matching transaction");

    // A clamped result sits exactly on a bound.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |-> (o_value == VAL_MAX || o_value == VAL_MIN))
        else $error("saturated result off the range bounds");

    // Position at t <= 0 is the segment start, exactly.
    a_pos_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(start && !busy && i_opcode == OP_POSITION &&
            (i_param_t[FRAC_BITS+1] || i_param_t == '0), PIPE_LATENCY))
        |-> (o_value == $past(i_segment_start, PIPE_LATENCY) && !o_saturated))
        else $error("position at t=0 differs from segment start");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the Catmull-Rom segment evaluator.
`timescale 1ns / 1ps
module tb_top;
    import crs_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;

    typedef struct {
        logic                 op;
        logic signed [CW-1:0] p_before;
        logic signed [CW-1:0] p_start;
        logic signed [CW-1:0] p_end;
        logic signed [CW-1:0] p_after;
        logic signed [FB+1:0] t;
    } t_seg_item;

    typedef struct {
        logic                 op;
        logic signed [CW-1:0] value;
        logic                 sat;
    } t_spline_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    wire                  busy;
    logic                 i_opcode = OP_POSITION;
    logic signed [CW-1:0] i_point_before = '0;
    logic signed [CW-1:0] i_segment_start = '0;
    logic signed [CW-1:0] i_segment_end = '0;
    logic signed [CW-1:0] i_point_after = '0;
    logic signed [FB+1:0] i_param_t = '0;
    wire                  o_strobe;
    wire signed [CW-1:0]  o_value;
    wire                  o_saturated;

    t_seg_item   pending_items[$];
    t_spline_out expected_points[$];
    t_seg_item   cur_item;
    int          idle_pct = 0;
    int          n_errors = 0;
    int          n_accepted = 0;
    int          n_position = 0;
    int          n_tangent = 0;
    int          n_clamped = 0;

    catmull_rom_spline_eval #(
        .COORD_WIDTH(CW),
        .FRAC_BITS  (FB)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_point_before (i_point_before),
        .i_segment_start(i_segment_start),
        .i_segment_end  (i_segment_end),
        .i_point_after  (i_point_after),
        .i_param_t      (i_param_t),
        .o_strobe       (o_strobe),
        .o_value        (o_value),
        .o_saturated    (o_saturated)
    );

    always #1 i_clk = ~i_clk;

    // Round-to-nearest rescale after a multiply by t, ties toward +inf.
    function automatic longint scale_by_t(longint x, longint t);
        return (x * t + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function automatic t_spline_out eval_segment(t_seg_item it);
        longint p0, p1, p2, p3, t, one, hi_lim, lo_lim;
        longint c0, c1, c2, c3, acc, res;
        t_spline_out r;
        p0 = it.p_before;
        p1 = it.p_start;
        p2 = it.p_end;
        p3 = it.p_after;
        t = it.t;
        one = longint'(1) <<< FB;
        hi_lim = (longint'(1) <<< (CW - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (t < 0) t = 0;
        if (t > one) t = one;
        c0 = 2 * p1;
        c1 = p2 - p0;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3 = -p0 + 3 * p1 - 3 * p2 + p3;
        if (it.op == OP_POSITION) begin
            acc = c2 + scale_by_t(c3, t);
            acc = c1 + scale_by_t(acc, t);
            acc = c0 + scale_by_t(acc, t);
        end else begin
            acc = 2 * c2 + scale_by_t(3 * c3, t);
            acc = c1 + scale_by_t(acc, t);
        end
        res = (acc + 1) >>> 1;
        r.op = it.op;
        r.sat = 1'b0;
        if (res > hi_lim) begin
            res = hi_lim;
            r.sat = 1'b1;
        end else if (res < lo_lim) begin
            res = lo_lim;
            r.sat = 1'b1;
        end
        r.value = res[CW-1:0];
        return r;
    endfunction

    // Driver: one transaction per accepting edge, random gaps per idle_pct.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_points.push_back(eval_segment(cur_item));
                n_accepted++;
            end
            if (!start || !busy) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_item = pending_items.pop_front();
                    start <= 1'b1;
                    i_opcode <= cur_item.op;
                    i_point_before <= cur_item.p_before;
                    i_segment_start <= cur_item.p_start;
                    i_segment_end <= cur_item.p_end;
                    i_point_after <= cur_item.p_after;
                    i_param_t <= cur_item.t;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe must match the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_spline_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result value %0d sat %0b", $time,
                         o_value, o_saturated);
                n_errors++;
            end else begin
                want = expected_points.pop_front();
                if (want.op == OP_POSITION) n_position++;
                else n_tangent++;
                if (want.sat) n_clamped++;
                if (o_value !== want.value) begin
                    $display("%0t: value mismatch expected %0d actual %0d", $time,
                             want.value, o_value);
                    n_errors++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated mismatch expected %0b actual %0b", $time,
                             want.sat, o_saturated);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic signed [CW-1:0] pick_coord();
        logic signed [CW-1:0] v;
        v = CW'($urandom);
        case ($urandom_range(9))
            0: v = {1'b1, {(CW-1){1'b0}}};
            1: v = {1'b0, {(CW-1){1'b1}}};
            2: v = '0;
            3, 4: v = v >>> $urandom_range(8, 28);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic signed [FB+1:0] pick_t();
        logic signed [FB+1:0] v;
        v = (FB+2)'($urandom);
        case ($urandom_range(11))
            0: ;
            1: v = '0;
            2: v = (FB+2)'(1 <<< FB);
            3: v = -$signed({1'b0, 17'($urandom_range(1, 1 << FB))});
            4: v = (FB+2)'((1 <<< FB) + $urandom_range(1, (1 << FB) - 1));
            default: v = (FB+2)'($urandom_range(0, 1 << FB));
        endcase
        return v;
    endfunction

    function automatic void queue_segment(logic op, logic signed [CW-1:0] a,
                                          logic signed [CW-1:0] b, logic signed [CW-1:0] c,
                                          logic signed [CW-1:0] d, logic signed [FB+1:0] t);
        t_seg_item it;
        it.op = op;
        it.p_before = a;
        it.p_start = b;
        it.p_end = c;
        it.p_after = d;
        it.t = t;
        pending_items.push_back(it);
    endfunction

    // Mostly path-like control points (a walk with small steps), rest noise.
    task automatic queue_random(int count);
        logic signed [CW-1:0] base;
        int                   shift;
        logic                 op;
        for (int k = 0; k < count; k++) begin
            op = $urandom_range(1) ? OP_TANGENT : OP_POSITION;
            if ($urandom_range(99) < 60) begin
                base = $signed(CW'($urandom)) >>> 3;
                shift = $urandom_range(8, 20);
                queue_segment(op, base,
                              base + ($signed(CW'($urandom)) >>> shift),
                              base + ($signed(CW'($urandom)) >>> (shift - 1)),
                              base + ($signed(CW'($urandom)) >>> (shift - 2)),
                              pick_t());
            end else begin
                queue_segment(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                              pick_t());
            end
        end
    endtask

    task automatic drain_sender();
        while (pending_items.size() > 0 || start) @(negedge i_clk);
    endtask

    initial begin
        localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
        localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
        localparam logic signed [FB+1:0] T_ONE = (FB+2)'(1 <<< FB);
        localparam logic signed [FB+1:0] T_HALF = (FB+2)'(1 <<< (FB - 1));
        localparam logic signed [FB+1:0] T_MIN = {1'b1, {(FB+1){1'b0}}};
        localparam logic signed [FB+1:0] T_MAX = {1'b0, {(FB+1){1'b1}}};
        int guard;

        // directed: extremes, both opcodes, t clamping, saturation both ways
        queue_segment(OP_POSITION, '0, '0, '0, '0, '0);
        queue_segment(OP_TANGENT, '0, '0, '0, '0, T_HALF);
        queue_segment(OP_POSITION, MAXC, MAXC, MAXC, MAXC, T_HALF);
        queue_segment(OP_POSITION, MINC, MINC, MINC, MINC, T_HALF);
        queue_segment(OP_POSITION, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh4_0000, '0);
        queue_segment(OP_POSITION, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh4_0000, T_ONE);
        queue_segment(OP_POSITION, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh4_0000, T_MIN);
        queue_segment(OP_POSITION, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh4_0000, T_MAX);
        queue_segment(OP_TANGENT, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh4_0000, T_MIN);
        queue_segment(OP_TANGENT, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh4_0000, T_MAX);
        queue_segment(OP_TANGENT, MINC, '0, MAXC, '0, '0);
        queue_segment(OP_TANGENT, MAXC, '0, MINC, '0, '0);
        queue_segment(OP_TANGENT, MINC, MAXC, MINC, MAXC, T_HALF);
        queue_segment(OP_POSITION, MINC, MAXC, MINC, MAXC, T_HALF);
        queue_segment(OP_POSITION, MAXC, MINC, MAXC, MINC, 18'sd21845);
        queue_segment(OP_POSITION, MINC, MAXC, MAXC, MINC, T_HALF);
        queue_segment(OP_POSITION, MAXC, MINC, MINC, MAXC, T_HALF);
        queue_segment(OP_TANGENT, MAXC, MINC, MINC, MAXC, T_ONE);
        queue_segment(OP_POSITION, -32'sd1, 32'sd1, -32'sd1, 32'sd1, 18'sd1);
        queue_segment(OP_TANGENT, -32'sd1, 32'sd1, -32'sd1, 32'sd1, T_ONE - 18'sd1);
        queue_segment(OP_POSITION, 32'sh0001_8000, -32'sh0000_4000, 32'sh7fff_0000,
                      -32'sh0123_4567, 18'sd12345);
        queue_random(430);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drain_sender();
        idle_pct = 71;
        queue_random(440);
        drain_sender();
        idle_pct = 9;
        queue_random(440);
        drain_sender();
        idle_pct = 0;
        queue_random(440);
        drain_sender();

        guard = 0;
        while (expected_points.size() > 0 && guard < 20 * PIPE_LATENCY) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);
        if (expected_points.size() > 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_points.size());
            n_errors += expected_points.size();
        end

        $display("Checked %0d transactions: %0d positions, %0d tangents, %0d clamped.",
                 n_accepted, n_position, n_tangent, n_clamped);
        $display("Sender gaps of 0, 71 and 9 percent; %0d errors.", n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Timeout after %0d transactions", n_accepted);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
